// File: rtl/sobs_pkg.sv
// ----------------------------------------------------------------------------
// sobs_pkg
// Shared types and constants for the set-of-bounded-stacks core.
// ----------------------------------------------------------------------------
package sobs_pkg;

  localparam int CMD_W     = 2;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 4;
  localparam int RES_W     = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;
  // spare code: taken and ignored
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd1;

  // value returned when nothing could be popped
  localparam logic [RES_W-1:0] RES_NONE   = 32'hFFFF_FFFF;

  // update request to the stack order map
  typedef struct packed {
    logic open;    // a new stack is appended
    logic remove;  // the stack at rm_pos became empty
  } map_op_t;

endpackage

// File: rtl/set_of_bounded_stacks_core.sv
// ----------------------------------------------------------------------------
// set_of_bounded_stacks_core
// Set of stacks of configurable capacity. Plates and per-slot fill counts sit
// in two memories with registered reads; a small order map tracks live stacks.
// ----------------------------------------------------------------------------
// Push: accept with fill read, then update. No result.
// Pop / pop-at: fill read, plate read, then result load; the result
//   is loaded into the output register from ST_DATA once the output is free.
// One command in flight at a time, set by the fill-then-plate memory chain.
// Reset: no stacks, identity order map, capacity 1. Memories are not cleared.
module set_of_bounded_stacks_core #(
  parameter int CAP_MAX    = 16,
  parameter int MAX_STACKS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sobs_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sobs_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [31:0]            in_value,
  input  logic [sobs_pkg::IDX_W-1:0]    in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_value_res,
  output logic                          out_empty_res
);

  localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int LIVE_W = $clog2(MAX_STACKS + 1);
  localparam int FILL_W = $clog2(CAP_MAX + 1);
  localparam int DEPTH  = MAX_STACKS * CAP_MAX;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAPC_W = (FILL_W > sobs_pkg::CFG_W) ? FILL_W : sobs_pkg::CFG_W;
  localparam int IDXC_W = (LIVE_W > sobs_pkg::IDX_W) ? LIVE_W : sobs_pkg::IDX_W;
  localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [sobs_pkg::CFG_W-1:0] cap_r;
  logic [sobs_pkg::CMD_W-1:0] cmd_r;
  logic [DATA_WIDTH-1:0]      value_r;
  logic                       empty_r;
  logic [SLOT_W-1:0]          pos_r;
  logic [SLOT_W-1:0]          slot_r;

  logic                       out_valid_r;
  logic [31:0]                out_value_r;
  logic                       out_empty_r;

  // memories
  logic [DATA_WIDTH-1:0] plate_mem [DEPTH];
  logic [FILL_W-1:0]     fill_mem  [MAX_STACKS];
  logic [DATA_WIDTH-1:0] st_rdata_r;
  logic [FILL_W-1:0]     fill_rdata_r;

  logic                  st_we, st_re;
  logic [ADDR_W-1:0]     st_waddr, st_raddr;
  logic                  fill_we, fill_re;
  logic [SLOT_W-1:0]     fill_waddr;
  logic [FILL_W-1:0]     fill_wdata;

  // order map
  sobs_pkg::map_op_t     map_op;
  logic [SLOT_W-1:0]     map_rd_pos, map_rd_slot;
  logic [LIVE_W-1:0]     live;

  logic                  in_fire, out_free;
  logic [SLOT_W-1:0]     acc_pos;
  logic                  acc_empty;
  logic [CAPC_W-1:0]     cap_x, cap_eff;
  logic                  last_full, can_open;
  logic [SLOT_W-1:0]     push_slot;
  logic [FILL_W-1:0]     push_base, fill_dec;
  logic [EXT_W-1:0]      in_ext, rd_ext;

  sobs_order_map #(
    .MAX_STACKS (MAX_STACKS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (map_op),
    .rm_pos  (pos_r),
    .rm_slot (slot_r),
    .rd_pos  (map_rd_pos),
    .rd_slot (map_rd_slot),
    .live    (live)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign acc_pos   = (in_cmd == sobs_pkg::CMD_POP_AT) ? SLOT_W'(in_index)
                                                       : SLOT_W'(live - LIVE_W'(1));
  assign acc_empty = ((in_cmd == sobs_pkg::CMD_POP) && (live == '0)) ||
                     ((in_cmd == sobs_pkg::CMD_POP_AT) &&
                      (IDXC_W'(in_index) >= IDXC_W'(live)));

  // during ST_FILL the map port looks up the slot a new stack would take
  assign map_rd_pos = (state_r == ST_IDLE) ? acc_pos : SLOT_W'(live);

  assign cap_x     = CAPC_W'(cap_r);
  assign cap_eff   = (cap_x > CAPC_W'(CAP_MAX)) ? CAPC_W'(CAP_MAX) : cap_x;
  assign last_full = (live == '0) || (CAPC_W'(fill_rdata_r) >= cap_eff);
  assign can_open  = (live < LIVE_W'(MAX_STACKS));
  assign push_slot = last_full ? map_rd_slot : slot_r;
  assign push_base = last_full ? '0 : fill_rdata_r;
  assign fill_dec  = fill_rdata_r - FILL_W'(1);

  assign in_ext = EXT_W'($unsigned(in_value));
  assign rd_ext = EXT_W'(st_rdata_r);

  always_comb begin
    state_nxt  = state_r;
    map_op     = '0;
    st_we      = 1'b0;
    st_re      = 1'b0;
    st_waddr   = ADDR_W'(push_slot) * ADDR_W'(CAP_MAX) + ADDR_W'(push_base);
    st_raddr   = ADDR_W'(slot_r) * ADDR_W'(CAP_MAX) + ADDR_W'(fill_dec);
    fill_we    = 1'b0;
    fill_re    = 1'b0;
    fill_waddr = slot_r;
    fill_wdata = fill_dec;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_cmd != sobs_pkg::CMD_NONE) begin
          fill_re   = 1'b1;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cmd_r == sobs_pkg::CMD_PUSH) begin
          state_nxt = ST_IDLE;
          if (cap_r != '0 && (!last_full || can_open)) begin
            st_we       = 1'b1;
            fill_we     = 1'b1;
            fill_waddr  = push_slot;
            fill_wdata  = push_base + FILL_W'(1);
            map_op.open = last_full;
          end
        end else begin
          state_nxt = ST_DATA;
          if (!empty_r) begin
            st_re         = 1'b1;
            fill_we       = 1'b1;
            map_op.remove = (fill_dec == '0);
          end
        end
      end
      ST_DATA: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      plate_mem[st_waddr] <= value_r;
    end
    if (st_re) begin
      st_rdata_r <= plate_mem[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rdata_r <= fill_mem[map_rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= sobs_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (state_r == ST_DATA && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      value_r <= in_ext[DATA_WIDTH-1:0];
      empty_r <= acc_empty;
      pos_r   <= acc_pos;
      slot_r  <= map_rd_slot;
    end
    if (state_r == ST_DATA && out_free) begin
      out_value_r <= empty_r ? sobs_pkg::RES_NONE : rd_ext[31:0];
      out_empty_r <= empty_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_empty_res = out_empty_r;

  // a pending beat must not be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_value_r)))
    else $error("result overwritten while stalled");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live <= LIVE_W'(MAX_STACKS))
    else $error("live stack count out of range");

  a_fill_follows_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> $past(state_r == ST_IDLE))
    else $error("fill stage entered without an accepted beat");

  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_we && cmd_r == sobs_pkg::CMD_PUSH) |-> (CAPC_W'(fill_wdata) <= cap_eff))
    else $error("push exceeds capacity");

  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    st_re |-> (live != '0 && fill_rdata_r != '0))
    else $error("plate read from an empty stack");

endmodule

// File: rtl/sobs_order_map.sv
// ----------------------------------------------------------------------------
// sobs_order_map
// Logical-to-physical slot map plus live stack count; removal shifts the
// later stacks down one place and parks the freed slot at the end.
// ----------------------------------------------------------------------------
module sobs_order_map #(
  parameter int MAX_STACKS = 16,
  localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1,
  localparam int LIVE_W = $clog2(MAX_STACKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sobs_pkg::map_op_t     op,
  input  logic [SLOT_W-1:0]     rm_pos,
  input  logic [SLOT_W-1:0]     rm_slot,
  input  logic [SLOT_W-1:0]     rd_pos,
  output logic [SLOT_W-1:0]     rd_slot,
  output logic [LIVE_W-1:0]     live
);

  logic [SLOT_W-1:0] order_r   [MAX_STACKS];
  logic [SLOT_W-1:0] order_nxt [MAX_STACKS];
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [SLOT_W-1:0] last_pos;

  assign last_pos = SLOT_W'(live_r - LIVE_W'(1));
  assign rd_slot  = order_r[rd_pos];
  assign live     = live_r;

  always_comb begin
    order_nxt = order_r;
    live_nxt  = live_r;
    if (op.remove) begin
      for (int i = 0; i < MAX_STACKS - 1; i++) begin
        if (SLOT_W'(i) >= rm_pos && LIVE_W'(i + 1) < live_r) begin
          order_nxt[i] = order_r[i + 1];
        end
      end
      order_nxt[last_pos] = rm_slot;
      live_nxt            = live_r - LIVE_W'(1);
    end else if (op.open) begin
      live_nxt = live_r + LIVE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        order_r[i] <= SLOT_W'(i);
      end
      live_r <= '0;
    end else begin
      order_r <= order_nxt;
      live_r  <= live_nxt;
    end
  end

endmodule
